// File: rtl/atrd_pkg.sv
// ----------------------------------------------------------------------------
// atrd_pkg
// Shared types, character codes and keyword tables for the AT response line
// decoder.
// ----------------------------------------------------------------------------
package atrd_pkg;

  localparam int unsigned LINE_MAX_DEF      = 32;
  localparam int unsigned KEYWORD_COUNT_DEF = 12;

  localparam int unsigned KW_TOTAL   = 12;
  localparam int unsigned KW_LEN_MAX = 6;
  localparam int unsigned KW_POS_W   = 3;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_EQ   = 8'h3d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_Z    = 8'h5a;

  typedef enum logic [3:0] {
    KIND_INITOK  = 4'd0,
    KIND_PWR     = 4'd1,
    KIND_PAIR    = 4'd2,
    KIND_VER     = 4'd3,
    KIND_AMP     = 4'd4,
    KIND_AG      = 4'd5,
    KIND_PEER    = 4'd6,
    KIND_AVRCP   = 4'd7,
    KIND_HLOST   = 4'd8,
    KIND_ALOST   = 4'd9,
    KIND_AUDIO   = 4'd10,
    KIND_LOST    = 4'd11,
    KIND_UNKNOWN = 4'd12
  } atrd_kind_t;

  // keyword text, right aligned: last character in the low byte
  localparam logic [KW_LEN_MAX*8-1:0] KW_TEXT [KW_TOTAL] = '{
    "INITOK", "PWR", "PAIR", "VER", "AMP", "AG",
    "PEER", "AVRCP", "HLOST", "ALOST", "AUDIO", "LOST"
  };
  localparam int unsigned KW_LEN [KW_TOTAL] = '{6, 3, 4, 3, 3, 2, 4, 5, 5, 5, 5, 4};

  typedef struct packed {
    logic [7:0] rx_byte;
  } atrd_rx_t;

  typedef struct packed {
    logic [3:0]        msg_kind;
    logic signed [7:0] hands_free_status;
    logic signed [7:0] media_link_status;
    logic signed [7:0] power_status;
    logic signed [7:0] audio_status;
    logic [7:0]        version_major;
    logic [7:0]        version_minor;
    logic              amp_start;
    logic              link_lost;
    logic              call_incoming;
    logic              paired;
    logic              streaming;
  } atrd_msg_t;

  // committed line characters as seen by the keyword tracker
  typedef struct packed {
    logic                open;
    logic                cr_en;
    logic [KW_POS_W-1:0] cr_pos;
    logic                ch_en;
    logic [KW_POS_W-1:0] ch_pos;
    logic [7:0]          ch;
  } atrd_kw_upd_t;

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [KW_POS_W-1:0] j);
    logic [KW_LEN_MAX*8-1:0] w;
    int                      sh;
    sh = int'(KW_LEN[k]) - 1 - int'(j);
    if (sh < 0) begin
      return 8'h00;
    end
    w = KW_TEXT[k] >> (8 * sh);
    return w[7:0];
  endfunction

endpackage

// File: rtl/atrd_chan_if.sv
// ----------------------------------------------------------------------------
// atrd_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface atrd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/at_response_line_decoder.sv
// ----------------------------------------------------------------------------
// at_response_line_decoder
// Frames received UART bytes into CR LF delimited lines and decodes the
// module's text indications into kind, status registers and event flags.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; input stalls only while a finished line
//   waits on a full, unaccepted result register.
// Line end: once the line's LF is accepted, stages s1 and s2 each read the
//   line store at two ports; stage s3 decodes once the result register is free.
// Reset: synchronous; hunt mode, statuses -1, version 0. The line store is
//   not cleared.
module at_response_line_decoder #(
  parameter int unsigned LINE_MAX      = atrd_pkg::LINE_MAX_DEF,
  parameter int unsigned KEYWORD_COUNT = atrd_pkg::KEYWORD_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  atrd_chan_if.sink   rx,
  atrd_chan_if.source msg
);
  import atrd_pkg::*;

  localparam int unsigned AW = $clog2(LINE_MAX);
  localparam int unsigned SW = AW + 1;
  localparam logic [AW-1:0] LAST   = AW'(LINE_MAX - 1);
  localparam logic [AW-1:0] KW_LIM = AW'(KW_LEN_MAX);

  typedef enum logic [1:0] {
    PH_HUNT_A,
    PH_HUNT_B,
    PH_LINE,
    PH_LINE_CR
  } phase_t;

  phase_t        phase, phase_next;
  logic [7:0]    held_byte, held_next;
  logic [AW-1:0] line_len, len_next;
  logic          scan_done, scan_done_next;
  logic [AW-1:0] scan_pos, scan_pos_next;
  logic [7:0]    stop_char, stop_next;

  logic          acc;
  logic [7:0]    b;
  logic          finish;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  atrd_kw_upd_t  kw_raw, kw_upd;
  atrd_kind_t    kind;

  logic [7:0]    line_mem [LINE_MAX];

  // line end pipeline
  logic          s1_v, s2_v, s3_v;
  atrd_kind_t    fin_kind;
  logic [AW-1:0] fin_p;
  logic [7:0]    fin_stop;
  logic [SW-1:0] sum_a, sum_b;
  logic          in_a, in_b;
  logic [AW-1:0] ia, ib;
  logic [7:0]    rd_a, rd_b;
  logic          oob_a, oob_b;
  logic [7:0]    c1, c2;
  logic [7:0]    d3, d4;
  logic          fire;

  logic [7:0]    hf, ml, pw, au, ver_major, ver_minor;
  logic [7:0]    hf_n, ml_n, pw_n, au_n, vmaj_n, vmin_n;
  logic          amp, lost;

  logic          out_valid;
  atrd_msg_t     out_data;

  assign b        = rx.payload.rx_byte;
  assign rx.ready = !(s3_v && out_valid && !msg.ready);
  assign acc      = rx.valid && rx.ready;

  // framing: a lone CR is written ahead at the current length and only
  // counted once the next byte shows it is not a line end
  always_comb begin
    logic [AW-1:0] n;
    n              = line_len;
    phase_next     = phase;
    held_next      = held_byte;
    len_next       = line_len;
    scan_done_next = scan_done;
    scan_pos_next  = scan_pos;
    stop_next      = stop_char;
    finish         = 1'b0;
    we             = 1'b0;
    wa             = line_len;
    wd             = b;
    kw_raw         = '0;
    kw_raw.ch      = b;
    case (phase)
      PH_HUNT_A: begin
        held_next  = b;
        phase_next = PH_HUNT_B;
      end
      PH_HUNT_B: begin
        if (held_byte == CH_CR && b == CH_LF) begin
          kw_raw.open    = 1'b1;
          len_next       = '0;
          scan_done_next = 1'b0;
          phase_next     = PH_LINE;
        end else begin
          phase_next = PH_HUNT_A;
        end
      end
      PH_LINE, PH_LINE_CR: begin
        if (phase == PH_LINE_CR && b == CH_LF) begin
          finish     = 1'b1;
          we         = 1'b1;
          wa         = line_len;
          wd         = '0;
          phase_next = PH_HUNT_A;
        end else begin
          if (phase == PH_LINE_CR && n < LAST) begin
            kw_raw.cr_en  = (n < KW_LIM);
            kw_raw.cr_pos = n[KW_POS_W-1:0];
            if (!scan_done_next) begin
              scan_done_next = 1'b1;
              scan_pos_next  = n;
              stop_next      = CH_CR;
            end
            n = n + AW'(1);
          end
          if (b == CH_CR) begin
            if (n < LAST) begin
              we = 1'b1;
              wa = n;
              wd = CH_CR;
            end
            phase_next = PH_LINE_CR;
          end else begin
            if (n < LAST) begin
              we            = 1'b1;
              wa            = n;
              wd            = b;
              kw_raw.ch_en  = (n < KW_LIM);
              kw_raw.ch_pos = n[KW_POS_W-1:0];
              if (!scan_done_next && !((b >= CH_A && b <= CH_Z) || b == CH_TWO)) begin
                scan_done_next = 1'b1;
                scan_pos_next  = n;
                stop_next      = b;
              end
              n = n + AW'(1);
            end
            phase_next = PH_LINE;
          end
          len_next = n;
        end
      end
      default: begin
        phase_next = PH_HUNT_A;
      end
    endcase
    kw_upd = acc ? kw_raw : '0;
  end

  atrd_kw_track #(
    .KEYWORD_COUNT(KEYWORD_COUNT)
  ) u_kw_track (
    .clk (clk),
    .rst (rst),
    .upd (kw_upd),
    .kind(kind)
  );

  // read addresses: p+1, p+2 in stage s1, p+3, p+4 in stage s2
  always_comb begin
    sum_a = {1'b0, fin_p} + (s1_v ? SW'(1) : SW'(3));
    sum_b = {1'b0, fin_p} + (s1_v ? SW'(2) : SW'(4));
    in_a  = sum_a < SW'(LINE_MAX);
    in_b  = sum_b < SW'(LINE_MAX);
    ia    = in_a ? sum_a[AW-1:0] : '0;
    ib    = in_b ? sum_b[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (acc && we) begin
      line_mem[wa] <= wd;
    end
    if (s1_v || s2_v) begin
      rd_a  <= line_mem[ia];
      rd_b  <= line_mem[ib];
      oob_a <= !in_a;
      oob_b <= !in_b;
    end
  end

  assign fire = s3_v && (!out_valid || msg.ready);
  assign d3   = oob_a ? 8'h00 : rd_a;
  assign d4   = oob_b ? 8'h00 : rd_b;

  always_comb begin
    hf_n   = hf;
    ml_n   = ml;
    pw_n   = pw;
    au_n   = au;
    vmaj_n = ver_major;
    vmin_n = ver_minor;
    amp    = 1'b0;
    lost   = 1'b0;
    case (fin_kind)
      KIND_PWR: begin
        if (fin_stop == CH_EQ) pw_n = c1 - CH_ZERO;
      end
      KIND_VER: begin
        if (fin_stop == CH_EQ) begin
          vmaj_n = c1;
          vmin_n = d3;
        end
      end
      KIND_AMP: begin
        amp = (fin_stop == CH_EQ) && (c1 == CH_ONE);
      end
      KIND_AG: begin
        if (c1 == CH_EQ) begin
          hf_n = c2 - CH_ZERO;
          ml_n = d4 - CH_ZERO;
        end
      end
      KIND_PEER: begin
        if (fin_stop == CH_EQ) ml_n = c1 - CH_ZERO;
      end
      KIND_AUDIO: begin
        if (fin_stop == CH_EQ) au_n = c1 - CH_ZERO;
      end
      KIND_HLOST, KIND_ALOST, KIND_LOST: begin
        lost = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT_A;
      held_byte <= '0;
      line_len  <= '0;
      scan_done <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
      hf        <= 8'hff;
      ml        <= 8'hff;
      pw        <= 8'hff;
      au        <= 8'hff;
      ver_major <= '0;
      ver_minor <= '0;
    end else begin
      if (acc) begin
        phase     <= phase_next;
        held_byte <= held_next;
        line_len  <= len_next;
        scan_done <= scan_done_next;
      end
      s1_v <= acc && finish;
      s2_v <= s1_v;
      if (s2_v) begin
        s3_v <= 1'b1;
      end else if (fire) begin
        s3_v <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        hf        <= hf_n;
        ml        <= ml_n;
        pw        <= pw_n;
        au        <= au_n;
        ver_major <= vmaj_n;
        ver_minor <= vmin_n;
      end else if (msg.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      scan_pos  <= scan_pos_next;
      stop_char <= stop_next;
    end
    if (acc && finish) begin
      fin_kind <= kind;
      fin_p    <= scan_done ? scan_pos : line_len;
      fin_stop <= scan_done ? stop_char : 8'h00;
    end
    if (s2_v) begin
      c1 <= d3;
      c2 <= d4;
    end
    if (fire) begin
      out_data.msg_kind          <= 4'(fin_kind);
      out_data.hands_free_status <= hf_n;
      out_data.media_link_status <= ml_n;
      out_data.power_status      <= pw_n;
      out_data.audio_status      <= au_n;
      out_data.version_major     <= vmaj_n;
      out_data.version_minor     <= vmin_n;
      out_data.amp_start         <= amp;
      out_data.link_lost         <= lost;
      out_data.call_incoming     <= (hf_n == 8'd4);
      out_data.paired            <= ($signed(hf_n) > 8'sd3) || ($signed(ml_n) > 8'sd2);
      out_data.streaming         <= ($signed(au_n) > 8'sd0);
    end
  end

  assign msg.valid   = out_valid;
  assign msg.payload = out_data;

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({s1_v, s2_v, s3_v}))
    else $error("two lines in the line end pipeline");
  assert property (@(posedge clk) disable iff (rst)
    (acc && we) |-> !(s1_v || s2_v))
    else $error("line store written during line end reads");
  assert property (@(posedge clk) disable iff (rst)
    line_len <= LAST)
    else $error("line length past the store");
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s3_v))
    else $error("result without a finished line");

endmodule

// File: rtl/atrd_kw_track.sv
// ----------------------------------------------------------------------------
// atrd_kw_track
// Tracks the keyword prefix match of the current line as its characters are
// committed; the kind is ready as soon as the line ends.
// ----------------------------------------------------------------------------
module atrd_kw_track #(
  parameter int unsigned KEYWORD_COUNT = atrd_pkg::KEYWORD_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  atrd_pkg::atrd_kw_upd_t upd,
  output atrd_pkg::atrd_kind_t   kind
);
  import atrd_pkg::*;

  localparam int unsigned KW_USED = (KEYWORD_COUNT < KW_TOTAL) ? KEYWORD_COUNT : KW_TOTAL;

  logic [KW_USED-1:0] ok;
  logic [KW_USED-1:0] done;
  logic [KW_USED-1:0] ok_next;
  logic [KW_USED-1:0] done_next;

  // up to two characters per item: a committed lone CR and the new byte
  always_comb begin
    for (int k = 0; k < KW_USED; k++) begin
      ok_next[k]   = ok[k];
      done_next[k] = done[k];
      if (upd.open) begin
        ok_next[k]   = 1'b1;
        done_next[k] = 1'b0;
      end
      if (upd.cr_en && !done_next[k]) begin
        if (kw_char(k, upd.cr_pos) != CH_CR) begin
          ok_next[k] = 1'b0;
        end
        if (int'(upd.cr_pos) + 1 == int'(KW_LEN[k])) begin
          done_next[k] = 1'b1;
        end
      end
      if (upd.ch_en && !done_next[k]) begin
        if (kw_char(k, upd.ch_pos) != upd.ch) begin
          ok_next[k] = 1'b0;
        end
        if (int'(upd.ch_pos) + 1 == int'(KW_LEN[k])) begin
          done_next[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    kind = KIND_UNKNOWN;
    for (int k = KW_USED - 1; k >= 0; k--) begin
      if (ok[k] && done[k]) begin
        kind = atrd_kind_t'(4'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ok   <= '0;
      done <= '0;
    end else begin
      ok   <= ok_next;
      done <= done_next;
    end
  end

  // a full match needs every keyword character, so done implies the window was reached
  assert property (@(posedge clk) disable iff (rst)
    upd.open |=> (done == '0))
    else $error("keyword tracker not cleared at line open");
  assert property (@(posedge clk) disable iff (rst)
    (upd.cr_en && upd.ch_en) |-> (upd.ch_pos == upd.cr_pos + 1'b1))
    else $error("keyword tracker characters out of order");
  assert property (@(posedge clk) disable iff (rst)
    (ok_next != ok) |-> (upd.open || upd.cr_en || upd.ch_en))
    else $error("keyword match state changed without a character");

endmodule
